// File: hdl/pit_pkg.sv
// Shared constants, codes and types for the page indirection table.
package pit_pkg;

  // Table geometry and field widths
  localparam int TABLE_DEPTH  = 4096;
  localparam int ADDR_W       = 12;
  localparam int OFFSET_W     = 48;
  localparam int MAX_OVERFLOW = 256;
  localparam int OVF_W        = 9;
  localparam int SLOT_W       = 21;
  localparam int PROD_W       = 20;
  localparam int REQ_W        = 14;
  localparam int CNT_W        = 13;
  localparam int SPP_W        = 12;
  localparam int REC_W        = 21;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_INLINE_SLOTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_PAGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_BYTES   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TAIL     = 2'd3;

  // Register reset values
  localparam logic [CNT_W-1:0]    RST_INLINE_SLOTS   = 13'd16;
  localparam logic [SPP_W-1:0]    RST_SLOTS_PER_PAGE = 12'd511;
  localparam logic [REC_W-1:0]    RST_RECORD_BYTES   = 21'd4096;
  localparam logic [OFFSET_W-1:0] RST_START_TAIL     = 48'd0;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ENSURE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STS_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NO_SPACE = 2'd2;

  // Allocation state as seen by the sequencer
  typedef struct packed {
    logic [SLOT_W-1:0]   total;     // unsaturated slot count
    logic [SLOT_W-1:0]   self_ref;  // self-reference slot of the next page
    logic [OFFSET_W-1:0] tail;      // current physical tail
    logic [OVF_W-1:0]    used;      // overflow pages allocated
    logic                full;      // no further overflow page may be added
  } alloc_t;

endpackage

// File: hdl/pit_ram.sv
// Generic single-port synchronous RAM with a registered read.
module pit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One access per cycle: write, or read into the output register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/pit_alloc.sv
// Configuration registers and overflow page allocation state.
module pit_alloc import pit_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 page_step,
  output alloc_t               alloc
);

  logic [CNT_W-1:0]    inline_r, inline_nxt;
  logic [SPP_W-1:0]    spp_r, spp_nxt;
  logic [REC_W-1:0]    record_r, record_nxt;
  logic [OFFSET_W-1:0] tail_r, tail_nxt;
  logic [OVF_W-1:0]    ovf_r, ovf_nxt;
  logic [PROD_W-1:0]   ovf_spp_r, ovf_spp_nxt;

  logic [CNT_W-1:0]       eff_inline;
  logic [SPP_W-1:0]       eff_spp;
  logic [SPP_W-1:0]       wr_spp;
  logic [OVF_W+SPP_W-1:0] wr_prod;

  // A zero register value acts as one.
  assign eff_inline = (inline_r == '0) ? CNT_W'(1) : inline_r;
  assign eff_spp    = (spp_r == '0) ? SPP_W'(1) : spp_r;

  // Product of pages and slots per page, rebuilt when slots per page changes.
  assign wr_spp  = (cfg_wdata[SPP_W-1:0] == '0) ? SPP_W'(1) : cfg_wdata[SPP_W-1:0];
  assign wr_prod = (OVF_W+SPP_W)'(ovf_r) * (OVF_W+SPP_W)'(wr_spp);

  // Register writes take priority; a page step only happens while busy.
  always_comb begin
    inline_nxt  = inline_r;
    spp_nxt     = spp_r;
    record_nxt  = record_r;
    tail_nxt    = tail_r;
    ovf_nxt     = ovf_r;
    ovf_spp_nxt = ovf_spp_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_INLINE_SLOTS:   inline_nxt = cfg_wdata[CNT_W-1:0];
        CFG_SLOTS_PER_PAGE: begin
          spp_nxt     = cfg_wdata[SPP_W-1:0];
          ovf_spp_nxt = wr_prod[PROD_W-1:0];
        end
        CFG_RECORD_BYTES:   record_nxt = cfg_wdata[REC_W-1:0];
        CFG_START_TAIL:     tail_nxt = cfg_wdata[OFFSET_W-1:0];
        default:            inline_nxt = inline_r;
      endcase
    end else if (page_step) begin
      tail_nxt    = tail_r + OFFSET_W'(record_r);
      ovf_nxt     = ovf_r + OVF_W'(1);
      ovf_spp_nxt = ovf_spp_r + PROD_W'(eff_spp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inline_r  <= RST_INLINE_SLOTS;
      spp_r     <= RST_SLOTS_PER_PAGE;
      record_r  <= RST_RECORD_BYTES;
      tail_r    <= RST_START_TAIL;
      ovf_r     <= '0;
      ovf_spp_r <= '0;
    end else begin
      inline_r  <= inline_nxt;
      spp_r     <= spp_nxt;
      record_r  <= record_nxt;
      tail_r    <= tail_nxt;
      ovf_r     <= ovf_nxt;
      ovf_spp_r <= ovf_spp_nxt;
    end
  end

  // Status handed to the sequencer.
  assign alloc.total    = SLOT_W'(eff_inline) + SLOT_W'(ovf_spp_r);
  assign alloc.self_ref = SLOT_W'(eff_inline) - SLOT_W'(1) + SLOT_W'(ovf_spp_r);
  assign alloc.tail     = tail_r;
  assign alloc.used     = ovf_r;
  assign alloc.full     = (ovf_r >= OVF_W'(MAX_OVERFLOW));

endmodule

// File: hdl/page_indirection_table_core.sv
// Top level of the page indirection table: command sequencer around the entry RAM.
//
// A request is taken when start is high and busy is low; its single result
// appears on the out_ ports for exactly one cycle with out_valid high, and the
// receiver cannot hold it off. For a lookup the accept cycle starts the
// entry RAM read and the execute state uses it, since the RAM has a single
// port with a registered read. An ensure request stays in execute while it
// adds its overflow pages, one page per cycle unless a configuration write
// holds a step back. The result shows in the cycle after the last execute
// cycle, and busy is already low then. After reset the block clears the
// 4096-entry RAM, one entry per cycle, and holds busy high until the last
// entry is cleared; configuration writes, taken in any state, beat a page step.
module page_indirection_table_core import pit_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Request channel
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [ADDR_W-1:0]    in_logical_index,
  input  logic [OFFSET_W-1:0]  in_phys_offset,
  input  logic [CNT_W-1:0]     in_pages_in_use,
  input  logic [CNT_W-1:0]     in_pages_needed,
  // Result channel
  output logic                 out_valid,
  output logic [OFFSET_W-1:0]  out_entry_value,
  output logic [STATUS_W-1:0]  out_status,
  output logic [OVF_W-1:0]     out_overflow_used,
  // Configuration port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;

  logic [CMD_W-1:0]    cmd_r;
  logic [ADDR_W-1:0]   idx_r;
  logic [OFFSET_W-1:0] val_r;
  logic [REQ_W-1:0]    req_r;

  logic                out_valid_r, out_valid_nxt;
  logic [OFFSET_W-1:0] out_value_r, out_value_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [OVF_W-1:0]    out_used_r, out_used_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [OFFSET_W-1:0] ram_wdata;
  logic [OFFSET_W-1:0] ram_rdata;

  logic                page_step;
  logic                accept;
  logic                in_range;
  logic                need_page;
  logic                self_in_table;
  alloc_t              alloc;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Allocation state and configuration registers.
  pit_alloc u_alloc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .page_step (page_step),
    .alloc     (alloc)
  );

  // Entry store.
  pit_ram #(
    .WIDTH (OFFSET_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Index below the table end; the end is left unsaturated, since a
  // twelve-bit index never reaches the depth.
  assign in_range      = (SLOT_W'(idx_r) < alloc.total);
  assign need_page     = (SLOT_W'(req_r) >= alloc.total);
  assign self_in_table = (alloc.self_ref[SLOT_W-1:ADDR_W] == '0);

  // Sequencer: clearing pass, idle with RAM read, and execute.
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    ram_we         = 1'b0;
    ram_addr       = in_logical_index;
    ram_wdata      = '0;
    page_step      = 1'b0;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = '0;
    out_status_nxt = STS_OK;
    out_used_nxt   = alloc.used;
    unique case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd_r)
          CMD_LOOKUP: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (in_range) begin
              out_value_nxt = ram_rdata;
            end else begin
              out_status_nxt = STS_RANGE;
            end
          end
          CMD_SET: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            ram_addr      = idx_r;
            ram_wdata     = val_r;
            if (in_range) begin
              ram_we = 1'b1;
            end else begin
              out_status_nxt = STS_RANGE;
            end
          end
          CMD_ENSURE: begin
            ram_addr  = alloc.self_ref[ADDR_W-1:0];
            ram_wdata = alloc.tail;
            if (need_page && !alloc.full) begin
              // Add one overflow page and, if its self-reference slot lies in the table, point it at the page.
              page_step = 1'b1;
              ram_we    = self_in_table;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
              if (need_page) begin
                out_status_nxt = STS_NO_SPACE;
              end
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      idx_r <= in_logical_index;
      val_r <= in_phys_offset;
      req_r <= REQ_W'(in_pages_in_use) + REQ_W'(in_pages_needed);
    end
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_used_r   <= out_used_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_entry_value   = out_value_r;
  assign out_status        = out_status_r;
  assign out_overflow_used = out_used_r;

  // A result strobe is never followed directly by another.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // The RAM is never written while the sequencer waits for a request.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("entry RAM written while idle");

  // An accepted request always moves into the execute state.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted request did not execute");

  // No-space is only reported with every overflow page in use.
  a_nospace_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STS_NO_SPACE)) |->
      (out_overflow_used == OVF_W'(MAX_OVERFLOW)))
    else $error("no-space status with overflow pages left");

  // Page steps happen only while executing and while the table is not full.
  a_step_exec: assert property (@(posedge clk) disable iff (!rst_n)
    page_step |-> (state_r == S_EXEC) && !alloc.full)
    else $error("overflow page added outside execute");

endmodule

// File: sim/tb.sv
// Self-checking testbench for the page indirection table core.
module tb;
  import pit_pkg::*;

  // Command code with no meaning to the block; it must leave the state alone.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REQ_MAX      = 16382;
  localparam int CNT_MAX      = 8191;
  localparam int ITEMS_PER_PH = 200;

  typedef struct {
    logic [CMD_W-1:0]    command;
    logic [ADDR_W-1:0]   index;
    logic [OFFSET_W-1:0] offset;
    logic [CNT_W-1:0]    in_use;
    logic [CNT_W-1:0]    needed;
  } request_t;

  typedef struct {
    logic [OFFSET_W-1:0] entry;
    logic [STATUS_W-1:0] status;
    logic [OVF_W-1:0]    overflow;
  } result_t;

  typedef struct {
    request_t req;
    bit       typed;
    result_t  res;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [CMD_W-1:0]     in_command;
  logic [ADDR_W-1:0]    in_logical_index;
  logic [OFFSET_W-1:0]  in_phys_offset;
  logic [CNT_W-1:0]     in_pages_in_use;
  logic [CNT_W-1:0]     in_pages_needed;
  logic                 out_valid;
  logic [OFFSET_W-1:0]  out_entry_value;
  logic [STATUS_W-1:0]  out_status;
  logic [OVF_W-1:0]     out_overflow_used;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Mirror of the table state and its registers.
  logic [OFFSET_W-1:0] map_store [TABLE_DEPTH];
  int unsigned         pages_added;
  int unsigned         cap_end;
  logic [OFFSET_W-1:0] tail_ptr;
  int unsigned         reg_inline;
  int unsigned         reg_spp;
  int unsigned         reg_record;
  logic [OFFSET_W-1:0] reg_start;

  result_t       pending_results [$];
  directed_row_t directed_rows [$];
  logic [ADDR_W-1:0] recent_sets [8];
  int  faults      = 0;
  int  cycle_count = 0;
  bit  no_gaps     = 1'b0;

  page_indirection_table_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_logical_index  (in_logical_index),
    .in_phys_offset    (in_phys_offset),
    .in_pages_in_use   (in_pages_in_use),
    .in_pages_needed   (in_pages_needed),
    .out_valid         (out_valid),
    .out_entry_value   (out_entry_value),
    .out_status        (out_status),
    .out_overflow_used (out_overflow_used),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // Clock with a period of 12 units.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Zero registers behave as one.
  function automatic int unsigned eff_inline();
    return (reg_inline == 0) ? 1 : reg_inline;
  endfunction

  function automatic int unsigned eff_spp();
    return (reg_spp == 0) ? 1 : reg_spp;
  endfunction

  // Slot count before saturation at the table depth.
  function automatic int unsigned slot_total();
    return eff_inline() + pages_added * eff_spp();
  endfunction

  function automatic void refresh_capacity();
    cap_end = (slot_total() > TABLE_DEPTH) ? TABLE_DEPTH : slot_total();
  endfunction

  function automatic void map_reset();
    foreach (map_store[i]) map_store[i] = '0;
    reg_inline  = 32'(RST_INLINE_SLOTS);
    reg_spp     = 32'(RST_SLOTS_PER_PAGE);
    reg_record  = 32'(RST_RECORD_BYTES);
    reg_start   = RST_START_TAIL;
    pages_added = 0;
    tail_ptr    = reg_start;
    refresh_capacity();
  endfunction

  function automatic void map_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    case (idx)
      CFG_INLINE_SLOTS:   reg_inline = 32'(value[CNT_W-1:0]);
      CFG_SLOTS_PER_PAGE: reg_spp    = 32'(value[SPP_W-1:0]);
      CFG_RECORD_BYTES:   reg_record = 32'(value[REC_W-1:0]);
      CFG_START_TAIL: begin
        reg_start = value[OFFSET_W-1:0];
        tail_ptr  = reg_start;
      end
      default: ;
    endcase
    refresh_capacity();
  endfunction

  // Works out the result of one request and moves the mirrored state on.
  function automatic result_t map_request(request_t r);
    result_t     res;
    int unsigned required;
    int unsigned self_slot;
    bit          stop;
    res.entry  = '0;
    res.status = STS_OK;
    case (r.command)
      CMD_LOOKUP: begin
        if (r.index < cap_end) res.entry = map_store[r.index];
        else res.status = STS_RANGE;
      end
      CMD_SET: begin
        if (r.index < cap_end) map_store[r.index] = r.offset;
        else res.status = STS_RANGE;
      end
      CMD_ENSURE: begin
        required = int'(r.in_use) + int'(r.needed);
        stop = 1'b0;
        while (!stop && required >= slot_total()) begin
          if (pages_added >= MAX_OVERFLOW) begin
            res.status = STS_NO_SPACE;
            stop = 1'b1;
          end else begin
            // The new page records its own address in its self-reference slot.
            self_slot = eff_inline() - 1 + pages_added * eff_spp();
            if (self_slot < TABLE_DEPTH) map_store[self_slot] = tail_ptr;
            tail_ptr = tail_ptr + OFFSET_W'(reg_record);
            pages_added++;
          end
        end
        refresh_capacity();
      end
      default: ;
    endcase
    res.overflow = pages_added[OVF_W-1:0];
    return res;
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] idx,
                         input logic [OFFSET_W-1:0] off, input logic [CNT_W-1:0] used,
                         input logic [CNT_W-1:0] need, input bit typed,
                         input logic [OFFSET_W-1:0] e, input logic [STATUS_W-1:0] s,
                         input logic [OVF_W-1:0] o);
    directed_row_t row;
    row.req   = '{cmd, idx, off, used, need};
    row.typed = typed;
    row.res   = '{e, s, o};
    directed_rows.push_back(row);
  endtask

  // Drives one request from a falling edge and holds it until it is taken.
  task automatic send_request(input request_t req, input bit typed, input result_t typed_res);
    result_t predicted;
    in_command       <= req.command;
    in_logical_index <= req.index;
    in_phys_offset   <= req.offset;
    in_pages_in_use  <= req.in_use;
    in_pages_needed  <= req.needed;
    start            <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) begin
      @(negedge clk);
      @(posedge clk);
    end
    predicted = map_request(req);
    if (typed) pending_results.push_back(typed_res);
    else pending_results.push_back(predicted);
    @(negedge clk);
  endtask

  // Mostly no gap, otherwise short gaps or a few long ones, and some stretches with none at all.
  task automatic sender_gap();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(99, 0);
    if (no_gaps || r < 55) len = 0;
    else if (r < 90) len = $urandom_range(3, 1);
    else len = $urandom_range(40, 8);
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(negedge clk);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    map_config(idx, value);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] inl, input logic [CFG_W-1:0] spp,
                            input logic [CFG_W-1:0] rec, input logic [CFG_W-1:0] tl);
    cfg_write(CFG_INLINE_SLOTS, inl);
    cfg_write(CFG_SLOTS_PER_PAGE, spp);
    cfg_write(CFG_RECORD_BYTES, rec);
    cfg_write(CFG_START_TAIL, tl);
  endtask

  // Waits for every outstanding result, then lets the block settle.
  task automatic wait_idle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Builds a request shaped by the current table size, so that most requests
  // hit the interesting edges: entries in range, the table end, and ensures
  // that add zero to a handful of pages.
  function automatic request_t random_request();
    request_t    r;
    int unsigned sel;
    int unsigned pick;
    int unsigned tot;
    int          target;
    int unsigned hi;
    int unsigned lo;
    r.command = CMD_LOOKUP;
    r.index   = ADDR_W'($urandom);
    r.offset  = OFFSET_W'({$urandom, $urandom});
    r.in_use  = CNT_W'($urandom);
    r.needed  = CNT_W'($urandom);
    sel = $urandom_range(99, 0);
    if (sel < 5) begin
      // Noise with fully random fields, never an ensure.
      pick = $urandom_range(2, 0);
      r.command = (pick == 0) ? CMD_LOOKUP : (pick == 1) ? CMD_SET : CMD_UNKNOWN;
    end else if (sel < 70) begin
      r.command = (sel < 40) ? CMD_LOOKUP : CMD_SET;
      pick = $urandom_range(9, 0);
      if (pick < 5) r.index = ADDR_W'($urandom_range(cap_end - 1, 0));
      else if (pick == 5) r.index = ADDR_W'(cap_end - 1);
      else if (pick == 6 && cap_end < TABLE_DEPTH) r.index = ADDR_W'(cap_end);
      else if (pick == 7 || pick == 8) r.index = recent_sets[$urandom_range(7, 0)];
      if (r.command == CMD_SET) recent_sets[$urandom_range(7, 0)] = r.index;
    end else if (sel < 95) begin
      r.command = CMD_ENSURE;
      tot = slot_total();
      if (tot <= REQ_MAX) begin
        if ($urandom_range(9, 0) < 7) begin
          target = int'(tot) + int'($urandom_range(6, 0)) - 3;
          if (target < 0) target = 0;
          if (target > REQ_MAX) target = REQ_MAX;
        end else begin
          target = int'($urandom_range(tot - 1, 0));
        end
        hi = (target < CNT_MAX) ? target : CNT_MAX;
        lo = (target > CNT_MAX) ? target - CNT_MAX : 0;
        r.in_use = CNT_W'($urandom_range(hi, lo));
        r.needed = CNT_W'(target - int'(r.in_use));
      end
    end else begin
      r.command = CMD_UNKNOWN;
    end
    return r;
  endfunction

  task automatic run_random(input int count);
    request_t req;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) no_gaps = ($urandom_range(3, 0) == 0);
      req = random_request();
      sender_gap();
      send_request(req, 1'b0, '{'0, '0, '0});
    end
    start <= 1'b0;
  endtask

  // Result checker: each strobe must match the oldest pending result.
  always @(posedge clk) begin : result_check
    result_t want;
    if (out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected result: entry %h status %0d overflow %0d",
                   out_entry_value, out_status, out_overflow_used);
      end else begin
        want = pending_results.pop_front();
        if (out_entry_value !== want.entry || out_status !== want.status ||
            out_overflow_used !== want.overflow) begin
          faults++;
          if (faults <= 10)
            $display("mismatch: entry %h/%h status %0d/%0d overflow %0d/%0d (expected/actual)",
                     want.entry, out_entry_value, want.status, out_status,
                     want.overflow, out_overflow_used);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    request_t last_req;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_command       = CMD_LOOKUP;
    in_logical_index = '0;
    in_phys_offset   = '0;
    in_pages_in_use  = '0;
    in_pages_needed  = '0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_INLINE_SLOTS;
    cfg_wdata        = '0;
    foreach (recent_sets[i]) recent_sets[i] = '0;
    map_reset();

    // Directed requests against the reset register values.
    add_row(CMD_LOOKUP, 12'd0, '0, '0, '0, 1, '0, STS_OK, 9'd0);
    add_row(CMD_LOOKUP, 12'd15, '0, '0, '0, 1, '0, STS_OK, 9'd0);
    add_row(CMD_LOOKUP, 12'd16, '0, '0, '0, 1, '0, STS_RANGE, 9'd0);
    add_row(CMD_LOOKUP, 12'd4095, '0, '0, '0, 1, '0, STS_RANGE, 9'd0);
    add_row(CMD_SET, 12'd16, '1, '0, '0, 1, '0, STS_RANGE, 9'd0);
    add_row(CMD_SET, 12'd0, '1, '0, '0, 1, '0, STS_OK, 9'd0);
    add_row(CMD_LOOKUP, 12'd0, '0, '0, '0, 1, '1, STS_OK, 9'd0);
    add_row(CMD_SET, 12'd15, 48'hAAAA_5555_AAAA, '0, '0, 1, '0, STS_OK, 9'd0);
    add_row(CMD_LOOKUP, 12'd15, '0, '0, '0, 0, '0, '0, '0);
    add_row(CMD_UNKNOWN, 12'd0, '1, '1, '1, 1, '0, STS_OK, 9'd0);
    add_row(CMD_LOOKUP, 12'd0, '0, '0, '0, 0, '0, '0, '0);
    add_row(CMD_ENSURE, 12'd0, '0, 13'd0, 13'd0, 1, '0, STS_OK, 9'd0);
    add_row(CMD_ENSURE, 12'd0, '0, 13'd15, 13'd0, 1, '0, STS_OK, 9'd0);
    add_row(CMD_ENSURE, 12'd0, '0, 13'd16, 13'd0, 1, '0, STS_OK, 9'd1);
    add_row(CMD_LOOKUP, 12'd15, '0, '0, '0, 1, '0, STS_OK, 9'd1);
    add_row(CMD_LOOKUP, 12'd526, '0, '0, '0, 1, '0, STS_OK, 9'd1);
    add_row(CMD_LOOKUP, 12'd527, '0, '0, '0, 1, '0, STS_RANGE, 9'd1);
    add_row(CMD_SET, 12'd526, 48'h5555_AAAA_5555, '0, '0, 0, '0, '0, '0);
    add_row(CMD_LOOKUP, 12'd526, '0, '0, '0, 0, '0, '0, '0);
    add_row(CMD_ENSURE, 12'd0, '0, 13'd0, 13'd2000, 0, '0, '0, '0);
    add_row(CMD_LOOKUP, 12'd526, '0, '0, '0, 0, '0, '0, '0);
    add_row(CMD_ENSURE, 12'd0, '0, 13'd8191, 13'd0, 0, '0, '0, '0);
    add_row(CMD_ENSURE, 12'd0, '0, 13'd0, 13'd8191, 0, '0, '0, '0);
    add_row(CMD_SET, 12'd4095, '1, '0, '0, 0, '0, '0, '0);
    add_row(CMD_LOOKUP, 12'd4095, '0, '0, '0, 0, '0, '0, '0);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      sender_gap();
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end
    run_random(ITEMS_PER_PH);

    // Inline area as large as the table, largest pages, smallest tail step.
    wait_idle();
    set_config(48'd4096, 48'd4095, 48'd1, 48'd0);
    run_random(ITEMS_PER_PH);

    // Two mid-range settings with small pages, so that the table grows.
    wait_idle();
    set_config(CFG_W'($urandom_range(600, 1)), CFG_W'($urandom_range(64, 16)),
               CFG_W'($urandom_range(1048576, 1)), CFG_W'({$urandom, $urandom}));
    run_random(ITEMS_PER_PH);

    wait_idle();
    set_config(CFG_W'($urandom_range(200, 1)), CFG_W'($urandom_range(24, 2)),
               CFG_W'($urandom_range(1048576, 1)), CFG_W'({$urandom, $urandom}));
    run_random(ITEMS_PER_PH);

    // Zero registers, a tail step of 1048576 and a tail that wraps, ending on a full table.
    wait_idle();
    set_config(48'd0, 48'd0, 48'd1048576, 48'hFFFF_FFFF_FF00);
    run_random(ITEMS_PER_PH);
    @(negedge clk);
    last_req = '{CMD_ENSURE, '0, '0, '1, '1};
    send_request(last_req, 1'b0, '{'0, '0, '0});
    last_req = '{CMD_ENSURE, '0, '0, 13'd1, 13'd0};
    send_request(last_req, 1'b0, '{'0, '0, '0});
    start <= 1'b0;

    wait_idle();
    repeat (10) @(posedge clk);
    if (faults == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/pit_pkg.sv
hdl/pit_ram.sv
hdl/pit_alloc.sv
hdl/page_indirection_table_core.sv
sim/tb.sv
